// File: design/modem_power_sequencer_defines.svh
// Assertion macros for the modem power sequencer.
// Included by modem_power_sequencer.sv; relies on ports clk and rst_n in scope.
`ifndef MODEM_POWER_SEQUENCER_DEFINES_SVH
`define MODEM_POWER_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
`define MPS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modem_power_sequencer: same-cycle check failed");
`define MPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modem_power_sequencer: next-cycle check failed");
`else
`define MPS_ASSERT(label, ante, cons)
`define MPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/mps_pkg.sv
// Types, codes and defaults shared by the modem power sequencer modules.
// No dependencies.
package mps_pkg;

  localparam int LEVEL_W = 12;
  localparam int WIDTH_W = 16;
  localparam int TIME_W  = 32;
  localparam int SEQ_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int EMERGENCY_ARM_MS_DEF   = 5000;
  localparam int EMERGENCY_PULSE_MS_DEF = 200;
  localparam int STATUS_BITS_DEF        = 12;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_RAIL_ON  = 4'd1,
    OP_RAIL_OFF = 4'd2,
    OP_BOOT     = 4'd3,
    OP_HW_OFF   = 4'd4,
    OP_ARM      = 4'd5,
    OP_FIRE     = 4'd6,
    OP_SLEEP    = 4'd7,
    OP_ABORT    = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    RC_OK       = 4'd0,
    RC_STATE    = 4'd1,
    RC_RANGE    = 4'd2,
    RC_PG       = 4'd3,
    RC_STATUS   = 4'd4,
    RC_THRESH   = 4'd5,
    RC_HIGH     = 4'd6,
    RC_UNSTABLE = 4'd7,
    RC_NOTARMED = 4'd8
  } rc_t;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_BOOT  = 2'd1,
    PK_HWOFF = 2'd2,
    PK_EMERG = 2'd3
  } pk_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFF_THRESHOLD    = 4'd0,
    REG_THRESHOLD_ENABLE = 4'd1,
    REG_OFF_STABLE_MS    = 4'd2,
    REG_SAMPLE_GAP_MS    = 4'd3,
    REG_BOOT_WIDTH_MIN   = 4'd4,
    REG_BOOT_WIDTH_MAX   = 4'd5,
    REG_HW_OFF_WIDTH_MIN = 4'd6,
    REG_HW_OFF_WIDTH_MAX = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [TIME_W-1:0]  now_ms;
    logic               supply_ok;
    logic               stat_new;
    logic               stat_ok;
    logic [LEVEL_W-1:0] status_level;
    logic [WIDTH_W-1:0] pulse_ms;
    logic               option_bit;
  } in_t;

  typedef struct packed {
    logic [3:0]       result_code;
    logic             rail_on;
    logic             pwm_forced;
    logic             sleep_allowed;
    logic             on_off_pin;
    logic             emergency_pin;
    logic             uart_allowed;
    logic [1:0]       active_pulse;
    logic [SEQ_W-1:0] pulse_count;
    logic             low_stable;
  } out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] off_threshold;
    logic               threshold_enabled;
    logic [15:0]        off_stable_ms;
    logic [15:0]        sample_gap_ms;
    logic [15:0]        boot_width_min;
    logic [15:0]        boot_width_max;
    logic [15:0]        hw_off_width_min;
    logic [15:0]        hw_off_width_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    off_threshold:     12'd0,
    threshold_enabled: 1'b0,
    off_stable_ms:     16'd1000,
    sample_gap_ms:     16'd500,
    boot_width_min:    16'd100,
    boot_width_max:    16'd5000,
    hw_off_width_min:  16'd2000,
    hw_off_width_max:  16'd10000
  };

  typedef struct packed {
    logic              rail_state;
    logic              pwm_state;
    logic              sleep_state;
    logic              boot_tried;
    pk_t               pulse_kind;
    logic [TIME_W-1:0] pulse_end;
    logic              armed;
    logic [TIME_W-1:0] arm_end;
    logic              low_tracking;
    logic              low_stable_flag;
    logic [TIME_W-1:0] low_since;
    logic [TIME_W-1:0] last_sample;
    logic [SEQ_W-1:0]  pulse_seq;
  } st_t;

  // Clears the stable-low tracker.
  function automatic st_t drop_trk(st_t s);
    st_t r;
    r = s;
    r.low_tracking    = 1'b0;
    r.low_stable_flag = 1'b0;
    r.low_since       = '0;
    r.last_sample     = '0;
    return r;
  endfunction

  // Clears any pulse and the emergency arm window.
  function automatic st_t drop_trans(st_t s);
    st_t r;
    r = s;
    r.pulse_kind = PK_NONE;
    r.pulse_end  = '0;
    r.armed      = 1'b0;
    r.arm_end    = '0;
    return r;
  endfunction

  // A deadline is reached once the wrapping difference is not negative.
  function automatic logic reached(logic [TIME_W-1:0] now, logic [TIME_W-1:0] dl);
    logic [TIME_W-1:0] d;
    d = now - dl;
    return ~d[TIME_W-1];
  endfunction

endpackage

// File: design/modem_power_sequencer.sv
// Modem supply power sequencer: input register, sequencer core, result register.
// Depends on mps_pkg, mps_cfg_regs, mps_core and modem_power_sequencer_defines.svh.
//
// Usage: each command item enters on in_valid/in_data and is transferred when
// in_stall is low. Every item yields exactly one result on out_valid/out_data,
// transferred when out_stall is low. Configuration registers are written on
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Writes must be made
// only while no item is in flight, which the block itself does not enforce.
// Writing any known register restarts the stable-low tracker; unknown indexes
// are ignored.
// Flow: an item taken into the input register passes through the core into the
// result register once that slot is free, and its result is then on out_valid.
// Throughput is one item per cycle unless the receiver stalls; the rate is set
// by the single-pass state update in the core, whose longest path is a 32-bit
// add followed by a 32-bit subtract for the stable-low deadline.
// Reset (rst_n low, synchronous) empties both registers, clears all
// sequencer state and loads the default configuration.
// When the receiver stalls, the result register holds; the input register
// holds its item and in_stall rises until the result register frees.
`include "modem_power_sequencer_defines.svh"

module modem_power_sequencer #(
  parameter int EMERGENCY_ARM_MS   = mps_pkg::EMERGENCY_ARM_MS_DEF,
  parameter int EMERGENCY_PULSE_MS = mps_pkg::EMERGENCY_PULSE_MS_DEF,
  parameter int STATUS_BITS        = mps_pkg::STATUS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mps_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mps_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data
);

  mps_pkg::cfg_t cfg;
  logic          trk_clr;
  logic          s1_v_r;
  mps_pkg::in_t  s1_r;
  logic          adv;
  mps_pkg::out_t result;
  logic          out_valid_r;
  mps_pkg::out_t out_data_r;

  mps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .trk_clr   (trk_clr)
  );

  mps_core #(
    .EMERGENCY_ARM_MS   (EMERGENCY_ARM_MS),
    .EMERGENCY_PULSE_MS (EMERGENCY_PULSE_MS),
    .STATUS_BITS        (STATUS_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .trk_clr (trk_clr),
    .step    (adv),
    .item    (s1_r),
    .result  (result)
  );

  // The held item moves into the result register whenever that slot is free
  // or being emptied in the same cycle.
  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MPS_ASSERT(a_pins_exclusive, out_valid, !(out_data.on_off_pin && out_data.emergency_pin))
  `MPS_ASSERT(a_uart_needs_rail, out_valid && out_data.uart_allowed,
              out_data.rail_on && out_data.active_pulse == mps_pkg::PK_NONE)
  `MPS_ASSERT(a_rail_off_clean, out_valid && !out_data.rail_on,
              !out_data.pwm_forced && !out_data.sleep_allowed &&
              out_data.active_pulse == mps_pkg::PK_NONE)
  `MPS_ASSERT(a_pulse_counted, out_valid && out_data.active_pulse != mps_pkg::PK_NONE,
              out_data.pulse_count != '0)
  `MPS_ASSERT_NEXT(a_stall_holds_item, in_stall, s1_v_r)

endmodule

// File: design/mps_cfg_regs.sv
// Configuration register file of the modem power sequencer.
// Depends on mps_pkg for the register layout, indexes and reset values.
module mps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mps_pkg::cfg_t                   cfg,
  output logic                            trk_clr
);

  mps_pkg::cfg_t cfg_r;
  mps_pkg::cfg_t cfg_nxt;
  logic          hit;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b1;
    case (cfg_index)
      mps_pkg::REG_OFF_THRESHOLD:    cfg_nxt.off_threshold     = cfg_data[mps_pkg::LEVEL_W-1:0];
      mps_pkg::REG_THRESHOLD_ENABLE: cfg_nxt.threshold_enabled = cfg_data[0];
      mps_pkg::REG_OFF_STABLE_MS:    cfg_nxt.off_stable_ms     = cfg_data;
      mps_pkg::REG_SAMPLE_GAP_MS:    cfg_nxt.sample_gap_ms     = cfg_data;
      mps_pkg::REG_BOOT_WIDTH_MIN:   cfg_nxt.boot_width_min    = cfg_data;
      mps_pkg::REG_BOOT_WIDTH_MAX:   cfg_nxt.boot_width_max    = cfg_data;
      mps_pkg::REG_HW_OFF_WIDTH_MIN: cfg_nxt.hw_off_width_min  = cfg_data;
      mps_pkg::REG_HW_OFF_WIDTH_MAX: cfg_nxt.hw_off_width_max  = cfg_data;
      default:                       hit = 1'b0;
    endcase
  end

  // Any write to a known register restarts the stable-low tracker.
  assign trk_clr = cfg_valid && cfg_ready && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= mps_pkg::CFG_RESET;
    end else if (trk_clr) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/mps_core.sv
// Sequencer state and the single-pass next-state and result logic.
// Depends on mps_pkg for item, result, config and state types.
module mps_core #(
  parameter int EMERGENCY_ARM_MS   = mps_pkg::EMERGENCY_ARM_MS_DEF,
  parameter int EMERGENCY_PULSE_MS = mps_pkg::EMERGENCY_PULSE_MS_DEF,
  parameter int STATUS_BITS        = mps_pkg::STATUS_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mps_pkg::cfg_t cfg,
  input  logic          trk_clr,
  input  logic          step,
  input  mps_pkg::in_t  item,
  output mps_pkg::out_t result
);

  localparam logic [31:0] SMASK32 = (32'd1 << STATUS_BITS) - 32'd1;
  localparam logic [mps_pkg::LEVEL_W-1:0] SMASK = SMASK32[mps_pkg::LEVEL_W-1:0];

  mps_pkg::st_t st_r;
  mps_pkg::st_t st_nxt;
  mps_pkg::rc_t rc;
  mps_pkg::pk_t start_kind;
  logic [mps_pkg::WIDTH_W-1:0] start_width;
  logic         start_req;
  logic         lvl_high;
  logic         gap;
  logic         stable_due;
  logic         arm_due;
  logic         pulse_due;
  logic         boot_ok;
  logic         hw_ok;
  logic         pulse_free;
  logic [mps_pkg::SEQ_W-1:0] seq_inc;

  always_comb begin
    st_nxt      = st_r;
    rc          = mps_pkg::RC_OK;
    start_req   = 1'b0;
    start_kind  = mps_pkg::PK_NONE;
    start_width = item.pulse_ms;

    lvl_high   = (item.status_level & SMASK) > (cfg.off_threshold & SMASK);
    gap        = st_r.low_tracking &&
                 ((item.now_ms - st_r.last_sample) > {16'd0, cfg.sample_gap_ms});
    stable_due = mps_pkg::reached(item.now_ms, st_r.low_since + {16'd0, cfg.off_stable_ms});
    arm_due    = mps_pkg::reached(item.now_ms, st_r.arm_end);
    pulse_due  = mps_pkg::reached(item.now_ms, st_r.pulse_end);
    boot_ok    = (item.pulse_ms >= cfg.boot_width_min) && (item.pulse_ms <= cfg.boot_width_max);
    hw_ok      = (item.pulse_ms >= cfg.hw_off_width_min) &&
                 (item.pulse_ms <= cfg.hw_off_width_max);
    pulse_free = st_r.rail_state && (st_r.pulse_kind == mps_pkg::PK_NONE);
    seq_inc    = st_r.pulse_seq + 1'b1;
    if (seq_inc == '0) begin
      seq_inc = {{(mps_pkg::SEQ_W-1){1'b0}}, 1'b1};
    end

    case (item.op)
      mps_pkg::OP_TICK: begin
        if (!st_r.rail_state) begin
          st_nxt.pwm_state   = 1'b0;
          st_nxt.sleep_state = 1'b0;
          st_nxt.boot_tried  = 1'b0;
          st_nxt = mps_pkg::drop_trans(mps_pkg::drop_trk(st_nxt));
        end else begin
          if (st_r.pulse_kind != mps_pkg::PK_NONE || !cfg.threshold_enabled || gap) begin
            st_nxt = mps_pkg::drop_trk(st_nxt);
          end
          if (item.stat_new) begin
            if (!item.stat_ok || lvl_high || st_r.pulse_kind != mps_pkg::PK_NONE ||
                !cfg.threshold_enabled) begin
              st_nxt = mps_pkg::drop_trk(st_nxt);
            end else if (!st_nxt.low_tracking) begin
              st_nxt.low_tracking    = 1'b1;
              st_nxt.low_stable_flag = 1'b0;
              st_nxt.low_since       = item.now_ms;
              st_nxt.last_sample     = item.now_ms;
            end else begin
              // Tracking survived this tick, so low_since is still the stored value.
              if (stable_due) begin
                st_nxt.low_stable_flag = 1'b1;
              end
              st_nxt.last_sample = item.now_ms;
            end
          end
          if (st_r.pulse_kind != mps_pkg::PK_NONE && (!item.supply_ok || pulse_due)) begin
            if (!item.supply_ok && st_r.pulse_kind == mps_pkg::PK_BOOT) begin
              st_nxt.boot_tried = 1'b0;
            end
            st_nxt.pulse_kind = mps_pkg::PK_NONE;
            st_nxt.pulse_end  = '0;
          end
          if (!item.supply_ok) begin
            st_nxt.boot_tried  = 1'b0;
            st_nxt.sleep_state = 1'b0;
            st_nxt.armed       = 1'b0;
            st_nxt.arm_end     = '0;
          end
          if (st_nxt.armed && arm_due) begin
            st_nxt.armed   = 1'b0;
            st_nxt.arm_end = '0;
          end
        end
      end
      mps_pkg::OP_RAIL_ON: begin
        if (st_r.rail_state) begin
          rc = mps_pkg::RC_STATE;
        end else begin
          st_nxt = mps_pkg::drop_trk(mps_pkg::drop_trans(st_nxt));
          st_nxt.rail_state  = 1'b1;
          st_nxt.pwm_state   = item.option_bit;
          st_nxt.sleep_state = 1'b0;
          st_nxt.boot_tried  = 1'b0;
        end
      end
      mps_pkg::OP_RAIL_OFF: begin
        if (!pulse_free) begin
          rc = mps_pkg::RC_STATE;
        end else if (!cfg.threshold_enabled) begin
          rc = mps_pkg::RC_THRESH;
        end else if (!item.stat_ok) begin
          rc = mps_pkg::RC_STATUS;
        end else if (lvl_high) begin
          rc = mps_pkg::RC_HIGH;
        end else if (!st_r.low_stable_flag) begin
          rc = mps_pkg::RC_UNSTABLE;
        end else begin
          st_nxt = mps_pkg::drop_trk(mps_pkg::drop_trans(st_nxt));
          st_nxt.rail_state  = 1'b0;
          st_nxt.pwm_state   = 1'b0;
          st_nxt.sleep_state = 1'b0;
          st_nxt.boot_tried  = 1'b0;
        end
      end
      mps_pkg::OP_BOOT: begin
        if (!boot_ok) begin
          rc = mps_pkg::RC_RANGE;
        end else begin
          start_req  = 1'b1;
          start_kind = mps_pkg::PK_BOOT;
        end
      end
      mps_pkg::OP_HW_OFF: begin
        // The width window is checked ahead of any state condition.
        if (!hw_ok) begin
          rc = mps_pkg::RC_RANGE;
        end else if (!st_r.boot_tried) begin
          rc = mps_pkg::RC_STATE;
        end else begin
          start_req  = 1'b1;
          start_kind = mps_pkg::PK_HWOFF;
        end
      end
      mps_pkg::OP_ARM: begin
        if (!pulse_free || !st_r.boot_tried) begin
          rc = mps_pkg::RC_STATE;
        end else if (!item.supply_ok) begin
          rc = mps_pkg::RC_PG;
        end else begin
          st_nxt.armed   = 1'b1;
          st_nxt.arm_end = item.now_ms + 32'(EMERGENCY_ARM_MS);
        end
      end
      mps_pkg::OP_FIRE: begin
        if (!st_r.armed || arm_due) begin
          rc = mps_pkg::RC_NOTARMED;
        end else begin
          // The arm is spent even if the pulse is then refused.
          st_nxt.armed   = 1'b0;
          st_nxt.arm_end = '0;
          start_req   = 1'b1;
          start_kind  = mps_pkg::PK_EMERG;
          start_width = mps_pkg::WIDTH_W'(EMERGENCY_PULSE_MS);
        end
      end
      mps_pkg::OP_SLEEP: begin
        if (!item.option_bit) begin
          st_nxt.sleep_state = 1'b0;
        end else if (!pulse_free) begin
          rc = mps_pkg::RC_STATE;
        end else if (!item.supply_ok) begin
          rc = mps_pkg::RC_PG;
        end else begin
          st_nxt.sleep_state = 1'b1;
        end
      end
      mps_pkg::OP_ABORT: begin
        if (st_r.pulse_kind == mps_pkg::PK_BOOT) begin
          st_nxt.boot_tried = 1'b0;
        end
        st_nxt = mps_pkg::drop_trans(st_nxt);
      end
      default: begin
        rc = mps_pkg::RC_STATE;
      end
    endcase

    if (start_req) begin
      if (!pulse_free) begin
        rc = mps_pkg::RC_STATE;
      end else if (!item.supply_ok) begin
        rc = mps_pkg::RC_PG;
      end else begin
        st_nxt = mps_pkg::drop_trk(st_nxt);
        st_nxt.sleep_state = 1'b0;
        st_nxt.armed       = 1'b0;
        st_nxt.arm_end     = '0;
        st_nxt.pulse_kind  = start_kind;
        st_nxt.pulse_end   = item.now_ms + {16'd0, start_width};
        st_nxt.pulse_seq   = seq_inc;
        if (start_kind == mps_pkg::PK_BOOT) begin
          st_nxt.boot_tried = 1'b1;
        end
      end
    end

    result.result_code   = rc;
    result.rail_on       = st_nxt.rail_state;
    result.pwm_forced    = st_nxt.pwm_state;
    result.sleep_allowed = st_nxt.sleep_state;
    result.on_off_pin    = (st_nxt.pulse_kind == mps_pkg::PK_BOOT) ||
                           (st_nxt.pulse_kind == mps_pkg::PK_HWOFF);
    result.emergency_pin = (st_nxt.pulse_kind == mps_pkg::PK_EMERG);
    result.uart_allowed  = st_nxt.rail_state && item.supply_ok &&
                           (st_nxt.pulse_kind == mps_pkg::PK_NONE);
    result.active_pulse  = st_nxt.pulse_kind;
    result.pulse_count   = st_nxt.pulse_seq;
    result.low_stable    = st_nxt.low_stable_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end else if (trk_clr) begin
      st_r <= mps_pkg::drop_trk(st_r);
    end
  end

endmodule

// File: sim/tb_modem_power_sequencer.sv
// Self-checking testbench for modem_power_sequencer: directed and random commands,
// several register settings, random idling on both channels, one result checked per command.
// Depends on mps_pkg and the modem_power_sequencer RTL.
module tb_modem_power_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_UNUSED_LO  = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
  localparam logic [3:0] REG_UNUSED_LO = 4'd8;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;
  localparam int ITEMS_PER_SETTING = 300;
  localparam int SETTINGS_RUN      = 6;
  localparam int QUIET_LIMIT       = 500;
  localparam int DRAIN_CYCLES      = 4;

  // Tracks the sequencer state and queues the result each command must produce.
  class pwr_seq_scoreboard;
    mps_pkg::cfg_t cfg;
    bit            rail, pwm, sleep, booted, armed, tracking, stable;
    mps_pkg::pk_t  pulse;
    bit [31:0]     pulse_end, arm_end, low_since, last_fresh;
    bit [15:0]     seq;
    mps_pkg::out_t pending[$];
    int unsigned   errors, checked, noted, writes;
    int unsigned   code_hits[9];

    function new();
      cfg = mps_pkg::CFG_RESET;
      {rail, pwm, sleep, booted} = '0;
      seq = '0;
      clear_tracker();
      clear_pulse_arm();
    endfunction

    function void clear_tracker();
      tracking = 1'b0;
      stable = 1'b0;
      low_since = '0;
      last_fresh = '0;
    endfunction

    function void clear_pulse_arm();
      pulse = mps_pkg::PK_NONE;
      pulse_end = '0;
      armed = 1'b0;
      arm_end = '0;
    endfunction

    // Deadlines compare by the sign of the wrapping difference.
    function bit deadline_passed(bit [31:0] now, bit [31:0] dl);
      bit [31:0] d;
      d = now - dl;
      return !d[31];
    endfunction

    function mps_pkg::rc_t launch_pulse(bit [31:0] now, bit pg, mps_pkg::pk_t kind,
                                        bit [31:0] width);
      if (!rail || pulse != mps_pkg::PK_NONE) return mps_pkg::RC_STATE;
      if (!pg) return mps_pkg::RC_PG;
      sleep = 1'b0;
      armed = 1'b0;
      arm_end = '0;
      clear_tracker();
      pulse = kind;
      pulse_end = now + width;
      seq = seq + 16'd1;
      if (seq == 16'd0) seq = 16'd1;
      return mps_pkg::RC_OK;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      writes++;
      case (idx)
        mps_pkg::REG_OFF_THRESHOLD:    cfg.off_threshold = data[11:0];
        mps_pkg::REG_THRESHOLD_ENABLE: cfg.threshold_enabled = data[0];
        mps_pkg::REG_OFF_STABLE_MS:    cfg.off_stable_ms = data;
        mps_pkg::REG_SAMPLE_GAP_MS:    cfg.sample_gap_ms = data;
        mps_pkg::REG_BOOT_WIDTH_MIN:   cfg.boot_width_min = data;
        mps_pkg::REG_BOOT_WIDTH_MAX:   cfg.boot_width_max = data;
        mps_pkg::REG_HW_OFF_WIDTH_MIN: cfg.hw_off_width_min = data;
        mps_pkg::REG_HW_OFF_WIDTH_MAX: cfg.hw_off_width_max = data;
        default: return;
      endcase
      clear_tracker();
    endfunction

    function void advance_time(mps_pkg::in_t c);
      bit [31:0] since;
      bit        gap;
      if (!rail) begin
        {pwm, sleep, booted} = '0;
        clear_tracker();
        clear_pulse_arm();
        return;
      end
      since = c.now_ms - last_fresh;
      gap = tracking && (since > 32'(cfg.sample_gap_ms));
      if (pulse != mps_pkg::PK_NONE || !cfg.threshold_enabled || gap) clear_tracker();
      if (c.stat_new) begin
        if (!c.stat_ok || c.status_level > cfg.off_threshold ||
            pulse != mps_pkg::PK_NONE || !cfg.threshold_enabled) begin
          clear_tracker();
        end else if (!tracking) begin
          tracking = 1'b1;
          stable = 1'b0;
          low_since = c.now_ms;
          last_fresh = c.now_ms;
        end else begin
          if (deadline_passed(c.now_ms, low_since + 32'(cfg.off_stable_ms))) stable = 1'b1;
          last_fresh = c.now_ms;
        end
      end
      // Losing power-good ends any pulse at once; a lost boot may be retried.
      if (pulse != mps_pkg::PK_NONE &&
          (!c.supply_ok || deadline_passed(c.now_ms, pulse_end))) begin
        if (!c.supply_ok && pulse == mps_pkg::PK_BOOT) booted = 1'b0;
        pulse = mps_pkg::PK_NONE;
        pulse_end = '0;
      end
      if (!c.supply_ok) begin
        booted = 1'b0;
        sleep = 1'b0;
        armed = 1'b0;
        arm_end = '0;
      end
      if (armed && deadline_passed(c.now_ms, arm_end)) begin
        armed = 1'b0;
        arm_end = '0;
      end
    endfunction

    function void note_command(mps_pkg::in_t c);
      mps_pkg::rc_t  rc;
      mps_pkg::out_t o;
      rc = mps_pkg::RC_OK;
      noted++;
      case (c.op)
        mps_pkg::OP_TICK: advance_time(c);
        mps_pkg::OP_RAIL_ON: begin
          if (rail) begin
            rc = mps_pkg::RC_STATE;
          end else begin
            clear_pulse_arm();
            rail = 1'b1;
            pwm = c.option_bit;
            sleep = 1'b0;
            booted = 1'b0;
            clear_tracker();
          end
        end
        mps_pkg::OP_RAIL_OFF: begin
          if (!rail || pulse != mps_pkg::PK_NONE) rc = mps_pkg::RC_STATE;
          else if (!cfg.threshold_enabled) rc = mps_pkg::RC_THRESH;
          else if (!c.stat_ok) rc = mps_pkg::RC_STATUS;
          else if (c.status_level > cfg.off_threshold) rc = mps_pkg::RC_HIGH;
          else if (!stable) rc = mps_pkg::RC_UNSTABLE;
          else begin
            {rail, pwm, sleep, booted} = '0;
            clear_tracker();
            clear_pulse_arm();
          end
        end
        mps_pkg::OP_BOOT: begin
          if (c.pulse_ms < cfg.boot_width_min || c.pulse_ms > cfg.boot_width_max) begin
            rc = mps_pkg::RC_RANGE;
          end else begin
            rc = launch_pulse(c.now_ms, c.supply_ok, mps_pkg::PK_BOOT, 32'(c.pulse_ms));
            if (rc == mps_pkg::RC_OK) booted = 1'b1;
          end
        end
        mps_pkg::OP_HW_OFF: begin
          // The width window is checked ahead of any state.
          if (c.pulse_ms < cfg.hw_off_width_min || c.pulse_ms > cfg.hw_off_width_max)
            rc = mps_pkg::RC_RANGE;
          else if (!booted) rc = mps_pkg::RC_STATE;
          else rc = launch_pulse(c.now_ms, c.supply_ok, mps_pkg::PK_HWOFF, 32'(c.pulse_ms));
        end
        mps_pkg::OP_ARM: begin
          if (!rail || !booted || pulse != mps_pkg::PK_NONE) rc = mps_pkg::RC_STATE;
          else if (!c.supply_ok) rc = mps_pkg::RC_PG;
          else begin
            armed = 1'b1;
            arm_end = c.now_ms + 32'(mps_pkg::EMERGENCY_ARM_MS_DEF);
          end
        end
        mps_pkg::OP_FIRE: begin
          // The arm is spent even when the pulse itself is refused.
          if (!armed || deadline_passed(c.now_ms, arm_end)) begin
            rc = mps_pkg::RC_NOTARMED;
          end else begin
            armed = 1'b0;
            arm_end = '0;
            rc = launch_pulse(c.now_ms, c.supply_ok, mps_pkg::PK_EMERG,
                              32'(mps_pkg::EMERGENCY_PULSE_MS_DEF));
          end
        end
        mps_pkg::OP_SLEEP: begin
          if (!c.option_bit) sleep = 1'b0;
          else if (!rail || pulse != mps_pkg::PK_NONE) rc = mps_pkg::RC_STATE;
          else if (!c.supply_ok) rc = mps_pkg::RC_PG;
          else sleep = 1'b1;
        end
        mps_pkg::OP_ABORT: begin
          if (pulse == mps_pkg::PK_BOOT) booted = 1'b0;
          clear_pulse_arm();
        end
        default: rc = mps_pkg::RC_STATE;
      endcase
      o.result_code   = rc;
      o.rail_on       = rail;
      o.pwm_forced    = pwm;
      o.sleep_allowed = sleep;
      o.on_off_pin    = (pulse == mps_pkg::PK_BOOT || pulse == mps_pkg::PK_HWOFF);
      o.emergency_pin = (pulse == mps_pkg::PK_EMERG);
      o.uart_allowed  = rail && c.supply_ok && pulse == mps_pkg::PK_NONE;
      o.active_pulse  = pulse;
      o.pulse_count   = seq;
      o.low_stable    = stable;
      pending.push_back(o);
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_output(mps_pkg::out_t got);
      mps_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("result transfer with no command outstanding: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.result_code < 9) code_hits[want.result_code]++;
      match("result_code", want.result_code, got.result_code);
      match("rail_on", want.rail_on, got.rail_on);
      match("pwm_forced", want.pwm_forced, got.pwm_forced);
      match("sleep_allowed", want.sleep_allowed, got.sleep_allowed);
      match("on_off_pin", want.on_off_pin, got.on_off_pin);
      match("emergency_pin", want.emergency_pin, got.emergency_pin);
      match("uart_allowed", want.uart_allowed, got.uart_allowed);
      match("active_pulse", want.active_pulse, got.active_pulse);
      match("pulse_count", want.pulse_count, got.pulse_count);
      match("low_stable", want.low_stable, got.low_stable);
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  mps_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  mps_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [3:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;

  pwr_seq_scoreboard sb = new();
  bit        steady = 1'b0;
  int        rx_hold = 0;
  int        quiet_cycles = 0;
  int        settings_done = 0;
  bit [31:0] clock_ms = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  modem_power_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver: after each result transfer, stall for a random number of cycles, unless steady.
  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_hold = steady ? 0 : $urandom_range(0, 4);
    else if (rx_hold > 0) rx_hold--;
    out_stall <= (rx_hold > 0);
  end

  // Every transfer is seen here with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_command(in_data);
      if (out_valid && !out_stall) sb.check_output(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("modem_power_sequencer test failed");
        $finish;
      end
    end
  end

  task automatic send_command(input mps_pkg::in_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Holds the sender until every outstanding result has been transferred.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input mps_pkg::cfg_t s);
    wait_for_results();
    cfg_write(mps_pkg::REG_OFF_THRESHOLD, 16'(s.off_threshold));
    cfg_write(mps_pkg::REG_THRESHOLD_ENABLE, 16'(s.threshold_enabled));
    cfg_write(mps_pkg::REG_OFF_STABLE_MS, s.off_stable_ms);
    cfg_write(mps_pkg::REG_SAMPLE_GAP_MS, s.sample_gap_ms);
    cfg_write(mps_pkg::REG_BOOT_WIDTH_MIN, s.boot_width_min);
    cfg_write(mps_pkg::REG_BOOT_WIDTH_MAX, s.boot_width_max);
    cfg_write(mps_pkg::REG_HW_OFF_WIDTH_MIN, s.hw_off_width_min);
    cfg_write(mps_pkg::REG_HW_OFF_WIDTH_MAX, s.hw_off_width_max);
    settings_done++;
  endtask

  function automatic mps_pkg::in_t cmd(logic [3:0] op, logic [31:0] now, logic pg,
                                       logic [15:0] width, logic opt);
    mps_pkg::in_t c;
    c = '0;
    c.op = op;
    c.now_ms = now;
    c.supply_ok = pg;
    c.stat_ok = 1'b1;
    c.pulse_ms = width;
    c.option_bit = opt;
    return c;
  endfunction

  // Mostly legal widths near the low end of the window, with its edges and any 16-bit value now and then.
  function automatic logic [15:0] pick_width(logic [15:0] lo, logic [15:0] hi);
    int span;
    if (lo > hi || $urandom_range(0, 9) == 0) return 16'($urandom);
    span = int'(hi) - int'(lo);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return lo + 16'($urandom_range(0, (span > 3000) ? 3000 : span));
    endcase
  endfunction

  function automatic mps_pkg::in_t make_random_command();
    mps_pkg::in_t c;
    int           r;
    c.op = 4'($urandom);
    c.now_ms = $urandom;
    c.supply_ok = 1'($urandom);
    c.stat_new = 1'($urandom);
    c.stat_ok = 1'($urandom);
    c.status_level = 12'($urandom);
    c.pulse_ms = 16'($urandom);
    c.option_bit = 1'($urandom);
    if ($urandom_range(0, 99) < 8) return c;
    // Time mostly moves forward in small steps; rare jumps exercise the wrap.
    if ($urandom_range(0, 99) < 3) clock_ms += $urandom;
    else clock_ms += $urandom_range(0, 250);
    c.now_ms = clock_ms;
    c.supply_ok = ($urandom_range(0, 99) < 92);
    c.stat_new = ($urandom_range(0, 99) < 75);
    c.stat_ok = ($urandom_range(0, 99) < 92);
    if ($urandom_range(0, 99) < 70)
      c.status_level = 12'($urandom_range(0, sb.cfg.off_threshold));
    r = $urandom_range(0, 99);
    if (!sb.rail && $urandom_range(0, 3) == 0) c.op = mps_pkg::OP_RAIL_ON;
    else if (r < 42) c.op = mps_pkg::OP_TICK;
    else if (r < 47) c.op = mps_pkg::OP_RAIL_ON;
    else if (r < 54) c.op = mps_pkg::OP_RAIL_OFF;
    else if (r < 63) c.op = mps_pkg::OP_BOOT;
    else if (r < 69) c.op = mps_pkg::OP_HW_OFF;
    else if (r < 77) c.op = mps_pkg::OP_ARM;
    else if (r < 85) c.op = mps_pkg::OP_FIRE;
    else if (r < 92) c.op = mps_pkg::OP_SLEEP;
    else if (r < 97) c.op = mps_pkg::OP_ABORT;
    else c.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (c.op == mps_pkg::OP_BOOT)
      c.pulse_ms = pick_width(sb.cfg.boot_width_min, sb.cfg.boot_width_max);
    else if (c.op == mps_pkg::OP_HW_OFF)
      c.pulse_ms = pick_width(sb.cfg.hw_off_width_min, sb.cfg.hw_off_width_max);
    return c;
  endfunction

  initial begin
    mps_pkg::in_t  c;
    mps_pkg::cfg_t s;
    bit [31:0]     t0;
    t0 = 32'hFFFF_FFC0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands under the reset configuration; the boot pulse end wraps past zero.
    send_command(cmd(mps_pkg::OP_TICK, 32'd0, 1'b0, 16'd0, 1'b0));
    send_command(cmd(OP_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
    send_command(cmd(mps_pkg::OP_RAIL_OFF, t0, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_BOOT, t0, 1'b1, 16'd100, 1'b0));
    send_command(cmd(mps_pkg::OP_RAIL_ON, t0, 1'b1, 16'd0, 1'b1));
    send_command(cmd(mps_pkg::OP_RAIL_ON, t0, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_HW_OFF, t0, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_HW_OFF, t0, 1'b1, 16'd2000, 1'b0));
    send_command(cmd(mps_pkg::OP_BOOT, t0, 1'b1, 16'd99, 1'b0));
    send_command(cmd(mps_pkg::OP_BOOT, t0, 1'b1, 16'd5001, 1'b0));
    send_command(cmd(mps_pkg::OP_BOOT, t0, 1'b0, 16'd100, 1'b0));
    send_command(cmd(mps_pkg::OP_ARM, t0, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_BOOT, t0 + 32'd10, 1'b1, 16'd100, 1'b0));
    c = cmd(mps_pkg::OP_TICK, t0 + 32'd60, 1'b1, 16'd0, 1'b0);
    c.stat_new = 1'b1;
    c.status_level = '1;
    send_command(c);
    send_command(cmd(mps_pkg::OP_TICK, t0 + 32'd110, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_ARM, t0 + 32'd111, 1'b0, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_ARM, t0 + 32'd112, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_FIRE, t0 + 32'd113, 1'b0, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_FIRE, t0 + 32'd114, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_ARM, t0 + 32'd115, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_FIRE, t0 + 32'd116, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_ABORT, t0 + 32'd117, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_SLEEP, t0 + 32'd118, 1'b1, 16'd0, 1'b1));
    send_command(cmd(mps_pkg::OP_RAIL_OFF, t0 + 32'd119, 1'b1, 16'd0, 1'b0));
    send_command(cmd(mps_pkg::OP_HW_OFF, t0 + 32'd120, 1'b1, 16'hFFFF, 1'b0));
    send_command(cmd(mps_pkg::OP_HW_OFF, t0 + 32'd121, 1'b1, 16'd2000, 1'b0));
    send_command(cmd(mps_pkg::OP_TICK, t0 + 32'd122, 1'b0, 16'd0, 1'b0));
    clock_ms = t0 + 32'd200;

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      s = mps_pkg::CFG_RESET;
      case (p)
        0: s = '{12'hFFF, 1'b1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
        1: begin
          s.off_threshold = 12'd0;
          s.threshold_enabled = 1'b1;
        end
        2: begin
          s.off_threshold = 12'($urandom);
          s.off_stable_ms = 16'($urandom_range(0, 3000));
          s.sample_gap_ms = 16'($urandom_range(100, 1000));
        end
        // Both width windows are empty here, so every boot and hardware-off request is out of range.
        3: s = '{12'h800, 1'b1, 16'd300, 16'd400, 16'd200, 16'd100, 16'hFFFF, 16'd0};
        4: begin
          s.off_threshold = 12'($urandom);
          s.threshold_enabled = 1'b1;
          s.off_stable_ms = 16'($urandom_range(0, 2000));
          s.sample_gap_ms = 16'($urandom_range(50, 600));
          s.boot_width_min = 16'($urandom_range(0, 500));
          s.boot_width_max = s.boot_width_min + 16'($urandom_range(0, 4000));
          s.hw_off_width_min = 16'($urandom_range(0, 3000));
          s.hw_off_width_max = s.hw_off_width_min + 16'($urandom_range(0, 8000));
        end
        default: s = '{12'h7FF, 1'b1, 16'hFFFF, 16'd0, 16'd100, 16'd5000, 16'd2000, 16'd10000};
      endcase
      apply_setting(s);
      if (p == 2) cfg_write(REG_UNUSED_LO, 16'hFFFF);
      if (p == 4) cfg_write(REG_UNUSED_HI, 16'($urandom));
      steady = (p == 1);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (p != 1 && n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
        send_command(make_random_command());
      end
    end
    steady = 1'b0;
    wait_for_results();

    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d commands and %0d register writes across %0d settings; %0d results checked.",
             sb.noted, sb.writes, settings_done, sb.checked);
    $display("Result codes seen, ok through not-armed: %p", sb.code_hits);
    if (sb.errors == 0) begin
      $display("modem_power_sequencer test passed");
    end else begin
      $display("modem_power_sequencer test failed");
    end
    $finish;
  end

endmodule
